FILE: hw/rtl/bsf_pkg.sv
// Shared constants, types and helper functions for the byte stream FIFO.
package bsf_pkg;

	localparam int MAX_DEPTH   = 64;
	localparam int ADDR_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CNT_W       = 7;
	localparam int BYTE_W      = 8;
	localparam int CMD_W       = 3;
	localparam int TOT_W       = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(MAX_DEPTH);
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_END   = 3'd4;

	typedef struct packed {
		logic [CNT_W-1:0] buffered_count;
		logic [CNT_W-1:0] free_space;
		logic [TOT_W-1:0] total_written;
		logic [TOT_W-1:0] total_read;
		logic             input_closed;
		logic             end_of_stream;
	} status_t;

	typedef struct packed {
		logic              has_bytes;
		logic [ADDR_W-1:0] start;
		logic [CNT_W-1:0]  n;
		logic              accepted;
		status_t           st;
	} job_t;

	typedef struct packed {
		logic full;
		logic byte_pending;
	} queue_status_t;

	// ring index plus offset; offset never exceeds the depth, so one correction
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(MAX_DEPTH)) begin
			sum = sum - (CNT_W+1)'(MAX_DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

	function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [TOT_W:0] sum;
		sum = {1'b0, a} + (TOT_W+1)'(b);
		return sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/bsf_if.sv
// Channel interfaces: command requests, results and the capacity write port.
interface bsf_req_if;
	logic                       valid;
	logic                       ready;
	logic [bsf_pkg::CMD_W-1:0]  cmd;
	logic [bsf_pkg::BYTE_W-1:0] write_byte;
	logic [bsf_pkg::CNT_W-1:0]  length;

	modport source (output valid, output cmd, output write_byte, output length, input ready);
	modport sink (input valid, input cmd, input write_byte, input length, output ready);
endinterface

interface bsf_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [bsf_pkg::BYTE_W-1:0] read_byte;
	logic                       byte_valid;
	logic                       last_result;
	logic                       accepted;
	logic [bsf_pkg::CNT_W-1:0]  buffered_count;
	logic [bsf_pkg::CNT_W-1:0]  free_space;
	logic [bsf_pkg::TOT_W-1:0]  total_written;
	logic [bsf_pkg::TOT_W-1:0]  total_read;
	logic                       input_closed;
	logic                       end_of_stream;

	modport source (output valid, output read_byte, output byte_valid, output last_result,
		output accepted, output buffered_count, output free_space, output total_written,
		output total_read, output input_closed, output end_of_stream, input ready);
	modport sink (input valid, input read_byte, input byte_valid, input last_result,
		input accepted, input buffered_count, input free_space, input total_written,
		input total_read, input input_closed, input end_of_stream, output ready);
endinterface

interface bsf_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [bsf_pkg::CNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/bsf_front.sv
// Front end: accepts commands, updates stream state, queues one job per command.
module bsf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	bsf_req_if.sink                       req,
	bsf_cfg_if.sink                       cfg,
	input  bsf_pkg::queue_status_t        q_status,
	output logic                          push,
	output bsf_pkg::job_t                 push_job,
	output logic                          ram_we,
	output logic [bsf_pkg::ADDR_W-1:0]    ram_waddr,
	output logic [bsf_pkg::BYTE_W-1:0]    ram_wdata
);

	logic [bsf_pkg::ADDR_W-1:0] head_q, head_n;
	logic [bsf_pkg::CNT_W-1:0]  count_q, count_n;
	logic                       done_q, done_n;
	logic [bsf_pkg::TOT_W-1:0]  wtot_q, wtot_n;
	logic [bsf_pkg::TOT_W-1:0]  rtot_q, rtot_n;
	logic [bsf_pkg::CNT_W-1:0]  cap_q;

	logic [bsf_pkg::CNT_W-1:0]  ecap, room, room_n, take_n;
	logic                       fire, acc, is_grab;

	assign cfg.ready = 1'b1;
	// hold off while a byte job waits: a write could land on bytes not yet read
	assign req.ready = !q_status.full && !q_status.byte_pending;
	assign fire      = req.valid && req.ready;

	assign ecap   = (cap_q > bsf_pkg::DEPTH_C) ? bsf_pkg::DEPTH_C : cap_q;
	assign room   = (done_q || count_q >= ecap) ? '0 : ecap - count_q;
	assign take_n = (req.length < count_q) ? req.length : count_q;

	always_comb begin
		head_n  = head_q;
		count_n = count_q;
		done_n  = done_q;
		wtot_n  = wtot_q;
		rtot_n  = rtot_q;
		acc     = 1'b0;
		is_grab = 1'b0;
		case (req.cmd)
			bsf_pkg::CMD_WRITE: begin
				acc = (room != '0);
				if (acc) begin
					count_n = count_q + 1'b1;
					wtot_n  = bsf_pkg::sat_add(wtot_q, 7'd1);
				end
			end
			bsf_pkg::CMD_PEEK: begin
				is_grab = 1'b1;
			end
			bsf_pkg::CMD_READ: begin
				is_grab = 1'b1;
				head_n  = bsf_pkg::wrap_add(head_q, take_n);
				count_n = count_q - take_n;
				rtot_n  = bsf_pkg::sat_add(rtot_q, take_n);
			end
			bsf_pkg::CMD_POP: begin
				head_n  = bsf_pkg::wrap_add(head_q, take_n);
				count_n = count_q - take_n;
				rtot_n  = bsf_pkg::sat_add(rtot_q, take_n);
			end
			bsf_pkg::CMD_END: begin
				done_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign room_n = (done_n || count_n >= ecap) ? '0 : ecap - count_n;

	always_comb begin
		push                       = fire;
		push_job.has_bytes         = is_grab && (take_n != '0);
		push_job.start             = head_q;
		push_job.n                 = take_n;
		push_job.accepted          = acc;
		push_job.st.buffered_count = count_n;
		push_job.st.free_space     = room_n;
		push_job.st.total_written  = wtot_n;
		push_job.st.total_read     = rtot_n;
		push_job.st.input_closed   = done_n;
		push_job.st.end_of_stream  = done_n && (count_n == '0);
	end

	assign ram_we    = fire && (req.cmd == bsf_pkg::CMD_WRITE) && acc;
	assign ram_waddr = bsf_pkg::wrap_add(head_q, count_q);
	assign ram_wdata = req.write_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
			wtot_q  <= '0;
			rtot_q  <= '0;
			cap_q   <= bsf_pkg::CAP_RESET;
		end else begin
			if (fire) begin
				head_q  <= head_n;
				count_q <= count_n;
				done_q  <= done_n;
				wtot_q  <= wtot_n;
				rtot_q  <= rtot_n;
			end
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
		end
	end

`ifndef SYNTHESIS
	a_write_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !q_status.byte_pending)
		else $error("store written while a byte job is pending");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bsf_pkg::DEPTH_C)
		else $error("stored count beyond ring depth");
`endif

endmodule

FILE: hw/rtl/bsf_queue.sv
// Short job queue between front and back ends.
module bsf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bsf_pkg::job_t          push_job,
	input  logic                   pop,
	output logic                   head_valid,
	output bsf_pkg::job_t          head_job,
	output bsf_pkg::queue_status_t status
);

	bsf_pkg::job_t                   ent_q [bsf_pkg::QUEUE_DEPTH];
	logic [bsf_pkg::QUEUE_DEPTH-1:0] vld_q, vld_n;
	logic [bsf_pkg::QPTR_W-1:0]      wptr_q, rptr_q;
	logic [bsf_pkg::QUEUE_DEPTH-1:0] grab_mask;

	always_comb begin
		for (int k = 0; k < bsf_pkg::QUEUE_DEPTH; k++) begin
			grab_mask[k] = vld_q[k] && ent_q[k].has_bytes;
		end
	end

	// pop and push never hit the same entry: push needs a free slot, pop a valid one
	always_comb begin
		vld_n = vld_q;
		if (pop) begin
			vld_n[rptr_q] = 1'b0;
		end
		if (push) begin
			vld_n[wptr_q] = 1'b1;
		end
	end

	assign head_valid          = vld_q[rptr_q];
	assign head_job            = ent_q[rptr_q];
	assign status.full         = vld_q[wptr_q];
	assign status.byte_pending = |grab_mask;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			vld_q <= vld_n;
			if (pop) begin
				rptr_q <= (rptr_q == bsf_pkg::QPTR_W'(bsf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rptr_q + 1'b1;
			end
			if (push) begin
				wptr_q <= (wptr_q == bsf_pkg::QPTR_W'(bsf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wptr_q + 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job popped from empty queue");
`endif

endmodule

FILE: hw/rtl/bsf_back.sv
// Back end: expands jobs into result items, reading stream bytes from the store.
module bsf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  bsf_pkg::job_t              head_job,
	output logic                       pop,
	output logic                       ram_re,
	output logic [bsf_pkg::ADDR_W-1:0] ram_raddr,
	input  logic [bsf_pkg::BYTE_W-1:0] ram_rdata,
	bsf_rsp_if.source                  rsp
);

	logic [bsf_pkg::ADDR_W-1:0] off_q;

	logic             s1_valid_s1;
	logic             s1_byte_s1;
	logic             s1_last_s1;
	logic             s1_acc_s1;
	bsf_pkg::status_t s1_st_s1;

	logic             rsp_valid_q;
	logic [bsf_pkg::BYTE_W-1:0] rsp_byte_q;
	logic             rsp_bv_q;
	logic             rsp_last_q;
	logic             rsp_acc_q;
	bsf_pkg::status_t rsp_st_q;

	logic out_free, s1_move, s1_free, issue, last_iss;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign s1_move  = s1_valid_s1 && out_free;
	assign s1_free  = !s1_valid_s1 || s1_move;
	assign issue    = head_valid && s1_free;
	assign last_iss = !head_job.has_bytes ||
		((bsf_pkg::CNT_W'(off_q) + 7'd1) == head_job.n);
	assign pop      = issue && last_iss;

	// read data stays put between issues, so s1 can wait on a stalled output
	assign ram_re    = issue && head_job.has_bytes;
	assign ram_raddr = bsf_pkg::wrap_add(head_job.start, bsf_pkg::CNT_W'(off_q));

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_byte_s1 <= head_job.has_bytes;
			s1_last_s1 <= last_iss;
			s1_acc_s1  <= head_job.accepted;
			s1_st_s1   <= head_job.st;
		end
		if (s1_move) begin
			rsp_byte_q <= s1_byte_s1 ? ram_rdata : '0;
			rsp_bv_q   <= s1_byte_s1;
			rsp_last_q <= s1_last_s1;
			rsp_acc_q  <= s1_acc_s1;
			rsp_st_q   <= s1_st_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			s1_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				off_q <= last_iss ? '0 : off_q + 1'b1;
			end
			if (issue) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_byte      = rsp_byte_q;
	assign rsp.byte_valid     = rsp_bv_q;
	assign rsp.last_result    = rsp_last_q;
	assign rsp.accepted       = rsp_acc_q;
	assign rsp.buffered_count = rsp_st_q.buffered_count;
	assign rsp.free_space     = rsp_st_q.free_space;
	assign rsp.total_written  = rsp_st_q.total_written;
	assign rsp.total_read     = rsp_st_q.total_read;
	assign rsp.input_closed   = rsp_st_q.input_closed;
	assign rsp.end_of_stream  = rsp_st_q.end_of_stream;

`ifndef SYNTHESIS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !out_free) |=> s1_valid_s1)
		else $error("stage 1 item dropped under stall");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (bsf_pkg::CNT_W'(off_q) < head_job.n))
		else $error("byte read beyond job length");
`endif

endmodule

FILE: hw/rtl/byte_stream_fifo.sv
// Top level of the byte stream FIFO: front end, job queue, back end and ring store.
//
//  channel | dir | handshake          | carries
//  --------+-----+--------------------+-------------------------------------------
//  req     | in  | req.valid/ready    | cmd, write_byte, length
//  rsp     | out | rsp.valid/ready    | read_byte, byte_valid, last_result, status
//  cfg     | in  | cfg.valid/ready    | data = capacity (always ready)
//
//  Write, pop, end input and unknown commands: one item per cycle unless rsp holds off,
//  one result each, passed through the job queue and stage 1 to the result register.
//  Peek/read of n bytes: n results, one per cycle unless rsp holds off, paced by the
//  one read port of the ring store; req stalls until the last byte of that job is read.
//  req also stalls when the two-entry job queue is full, which only happens while
//  rsp is held off. Reset is asynchronous and clears pointers, counts and totals;
//  the store itself is not cleared and needs no sweep after reset.
module byte_stream_fifo (
	input  logic      clk,
	input  logic      arst_n,
	bsf_req_if.sink   req,
	bsf_rsp_if.source rsp,
	bsf_cfg_if.sink   cfg
);

	bsf_pkg::queue_status_t     q_status;
	bsf_pkg::job_t              push_job, head_job;
	logic                       push, pop, head_valid;

	logic                       ram_we, ram_re;
	logic [bsf_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [bsf_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

	// front: stream state updates happen here in the accept cycle; the capacity loads on cfg.valid
	bsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.q_status  (q_status),
		.push      (push),
		.push_job  (push_job),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	// jobs carry the post-command status snapshot plus the byte window to stream
	bsf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.status     (q_status)
	);

	bsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.rsp        (rsp)
	);

	// ring store: written by the front, read by the back
	bsf_ram #(
		.WIDTH (bsf_pkg::BYTE_W),
		.DEPTH (bsf_pkg::MAX_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
